// ===== sv/tpc_pkg.sv =====
// Shared constants and types for the triangle pixel coverage core.
package tpc_pkg;

  localparam int COORD_BITS     = 12;
  localparam int TRI_ID_BITS    = 16;
  localparam int PIX_BITS       = 24;
  localparam int CFG_BITS       = 13;
  localparam int CFG_IDX_BITS   = 1;
  localparam int FRAME_BITS     = 2 * CFG_BITS;
  // Pixel column/row and vertex coordinates share one unsigned width.
  localparam int PT_BITS        = (CFG_BITS > COORD_BITS) ? CFG_BITS : COORD_BITS;
  localparam int DIFF_BITS      = PT_BITS + 1;
  localparam int PROD_BITS      = 2 * DIFF_BITS;
  localparam int SUM_BITS       = PROD_BITS + 2;
  localparam int AREA_BITS      = SUM_BITS - 1;
  localparam int DIV_STEP_BITS  = 2;
  localparam int DIV_STAGES     = PIX_BITS / DIV_STEP_BITS;
  localparam int AREA_STAGES    = 4;

  localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RST  = CFG_BITS'(640);
  localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RST = CFG_BITS'(480);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [TRI_ID_BITS-1:0] tri_id;
    logic [COORD_BITS-1:0]  a_x;
    logic [COORD_BITS-1:0]  a_y;
    logic [COORD_BITS-1:0]  b_x;
    logic [COORD_BITS-1:0]  b_y;
    logic [COORD_BITS-1:0]  c_x;
    logic [COORD_BITS-1:0]  c_y;
    logic [PIX_BITS-1:0]    pixel_index;
  } tpc_item_t;

  typedef struct packed {
    logic                valid;
    tpc_item_t           item;
    logic [CFG_BITS-1:0] px;
    logic [CFG_BITS-1:0] py;
  } tpc_div_out_t;

endpackage

// ===== sv/tpc_div_pipe.sv =====
// Pipelined restoring divider: splits the pixel index into column and row.
module tpc_div_pipe import tpc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  tpc_item_t           in_item,
  input  logic [CFG_BITS-1:0] divisor,
  output tpc_div_out_t        dout
);

  logic                vld_r   [DIV_STAGES];
  tpc_item_t           item_r  [DIV_STAGES];
  logic [CFG_BITS-1:0] rem_r   [DIV_STAGES];
  logic [CFG_BITS-1:0] quo_r   [DIV_STAGES];
  logic [CFG_BITS-1:0] rem_nxt [DIV_STAGES];
  logic [CFG_BITS-1:0] quo_nxt [DIV_STAGES];

  // Each stage retires DIV_STEP_BITS quotient bits, MSB first.
  // Only the low quotient bits are kept: row < frame height for in-frame items.
  always_comb begin
    logic [CFG_BITS:0]   trial;
    logic [CFG_BITS-1:0] rem_v;
    logic [CFG_BITS-1:0] quo_v;
    logic [PIX_BITS-1:0] idx_v;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        rem_v = '0;
        quo_v = '0;
        idx_v = in_item.pixel_index;
      end else begin
        rem_v = rem_r[s-1];
        quo_v = quo_r[s-1];
        idx_v = item_r[s-1].pixel_index;
      end
      for (int j = 0; j < DIV_STEP_BITS; j++) begin
        trial = {rem_v, idx_v[PIX_BITS-1-s*DIV_STEP_BITS-j]};
        if (trial >= {1'b0, divisor}) begin
          rem_v = CFG_BITS'(trial - {1'b0, divisor});
          quo_v = {quo_v[CFG_BITS-2:0], 1'b1};
        end else begin
          rem_v = trial[CFG_BITS-1:0];
          quo_v = {quo_v[CFG_BITS-2:0], 1'b0};
        end
      end
      rem_nxt[s] = rem_v;
      quo_nxt[s] = quo_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s < DIV_STAGES; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r[0] <= in_item;
      for (int s = 1; s < DIV_STAGES; s++) begin
        item_r[s] <= item_r[s-1];
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_r[s] <= rem_nxt[s];
        quo_r[s] <= quo_nxt[s];
      end
    end
  end

  assign dout.valid = vld_r[DIV_STAGES-1];
  assign dout.item  = item_r[DIV_STAGES-1];
  assign dout.px    = rem_r[DIV_STAGES-1];
  assign dout.py    = quo_r[DIV_STAGES-1];

endmodule

// ===== sv/tpc_area.sv =====
// Four-stage pipelined half-area unit: |trunc(doubled signed area / 2)|.
module tpc_area import tpc_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [PT_BITS-1:0]   x1,
  input  logic [PT_BITS-1:0]   y1,
  input  logic [PT_BITS-1:0]   x2,
  input  logic [PT_BITS-1:0]   y2,
  input  logic [PT_BITS-1:0]   x3,
  input  logic [PT_BITS-1:0]   y3,
  output logic [AREA_BITS-1:0] area
);

  // stage A: edge differences
  logic [PT_BITS-1:0]          x1_r, x2_r, x3_r;
  logic signed [DIFF_BITS-1:0] d1_r, d2_r, d3_r;
  logic signed [DIFF_BITS-1:0] d1_nxt, d2_nxt, d3_nxt;
  // stage B: products
  logic signed [PROD_BITS-1:0] p1_r, p2_r, p3_r;
  logic signed [PROD_BITS-1:0] p1_nxt, p2_nxt, p3_nxt;
  // stage C: doubled signed area
  logic signed [SUM_BITS-1:0]  twice_r, twice_nxt;
  // stage D: halved magnitude
  logic [SUM_BITS-1:0]         mag;
  logic [AREA_BITS-1:0]        area_r, area_nxt;

  always_comb begin
    d1_nxt = $signed({1'b0, y2}) - $signed({1'b0, y3});
    d2_nxt = $signed({1'b0, y3}) - $signed({1'b0, y1});
    d3_nxt = $signed({1'b0, y1}) - $signed({1'b0, y2});
    p1_nxt = PROD_BITS'($signed({1'b0, x1_r}) * d1_r);
    p2_nxt = PROD_BITS'($signed({1'b0, x2_r}) * d2_r);
    p3_nxt = PROD_BITS'($signed({1'b0, x3_r}) * d3_r);
    twice_nxt = SUM_BITS'(p1_r) + SUM_BITS'(p2_r) + SUM_BITS'(p3_r);
    // truncation toward zero then abs equals abs then floor halving
    mag      = twice_r[SUM_BITS-1] ? SUM_BITS'(-twice_r) : SUM_BITS'(twice_r);
    area_nxt = mag[SUM_BITS-1:1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= x1;
      x2_r    <= x2;
      x3_r    <= x3;
      d1_r    <= d1_nxt;
      d2_r    <= d2_nxt;
      d3_r    <= d3_nxt;
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
      p3_r    <= p3_nxt;
      twice_r <= twice_nxt;
      area_r  <= area_nxt;
    end
  end

  assign area = area_r;

endmodule

// ===== sv/triangle_pixel_coverage_core.sv =====
// Top level: area-sum point-in-triangle test over a streamed pixel index.
// Pipeline: 12 divider stages, 4 area stages, 1 compare stage and 1 output
//   register from input accept to out_valid.
// Throughput: one item per clock; the whole pipeline holds only while a hit
//   sits in the compare stage and the output register is full and not taken.
// Reset (rst_n low, synchronous): all valid bits clear, frame 640 x 480.
module triangle_pixel_coverage_core import tpc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // input items
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [TRI_ID_BITS-1:0]  in_tri_id,
  input  logic [COORD_BITS-1:0]   in_a_x,
  input  logic [COORD_BITS-1:0]   in_a_y,
  input  logic [COORD_BITS-1:0]   in_b_x,
  input  logic [COORD_BITS-1:0]   in_b_y,
  input  logic [COORD_BITS-1:0]   in_c_x,
  input  logic [COORD_BITS-1:0]   in_c_y,
  input  logic [PIX_BITS-1:0]     in_pixel_index,
  // result items
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [TRI_ID_BITS-1:0]  out_hit_tri_id,
  output logic [PIX_BITS-1:0]     out_hit_pixel_index,
  // configuration writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  // ---------------------------------------------------------------------
  // Configuration: width, height and their registered product (frame size).
  // The product is registered after the width/height registers; it settles before
  // an item accepted after the write reaches the frame check at the divider output.
  // ---------------------------------------------------------------------
  logic [CFG_BITS-1:0]   frame_width_r, frame_height_r;
  logic [FRAME_BITS-1:0] total_r, total_nxt;

  assign cfg_ready = 1'b1;
  assign total_nxt = FRAME_BITS'(frame_width_r) * FRAME_BITS'(frame_height_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      total_r        <= FRAME_BITS'(FRAME_WIDTH_RST) * FRAME_BITS'(FRAME_HEIGHT_RST);
    end else begin
      total_r <= total_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
          CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline enable. Every stage moves together; it only holds when a hit
  // in the compare stage cannot move into a full, untaken output register.
  // Misses and bubbles never block.
  // ---------------------------------------------------------------------
  logic pipe_en;
  logic e_valid_r, e_hit_r;
  logic out_valid_r;

  assign pipe_en  = !(e_valid_r && e_hit_r) || !out_valid_r || out_ready;
  assign in_ready = pipe_en;

  // ---------------------------------------------------------------------
  // Stage group 1: index -> column (remainder) and row (quotient).
  // ---------------------------------------------------------------------
  tpc_item_t    in_item;
  tpc_div_out_t dq;

  assign in_item.tri_id      = in_tri_id;
  assign in_item.a_x         = in_a_x;
  assign in_item.a_y         = in_a_y;
  assign in_item.b_x         = in_b_x;
  assign in_item.b_y         = in_b_y;
  assign in_item.c_x         = in_c_x;
  assign in_item.c_y         = in_c_y;
  assign in_item.pixel_index = in_pixel_index;

  tpc_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_valid (in_valid && in_ready),
    .in_item  (in_item),
    .divisor  (frame_width_r),
    .dout     (dq)
  );

  // ---------------------------------------------------------------------
  // Stage group 2: four half areas in parallel (whole, PBC, APC, ABP).
  // Sideband (valid, in-frame flag, id, index) rides alongside.
  // A zero width makes the frame size zero, so the in-frame flag drops.
  // ---------------------------------------------------------------------
  logic [PT_BITS-1:0] ax, ay, bx, by, cx, cy, px, py;
  logic [AREA_BITS-1:0] whole, s1, s2, s3;

  assign ax = PT_BITS'(dq.item.a_x);
  assign ay = PT_BITS'(dq.item.a_y);
  assign bx = PT_BITS'(dq.item.b_x);
  assign by = PT_BITS'(dq.item.b_y);
  assign cx = PT_BITS'(dq.item.c_x);
  assign cy = PT_BITS'(dq.item.c_y);
  assign px = PT_BITS'(dq.px);
  assign py = PT_BITS'(dq.py);

  tpc_area u_area_abc (.clk(clk), .en(pipe_en),
    .x1(ax), .y1(ay), .x2(bx), .y2(by), .x3(cx), .y3(cy), .area(whole));
  tpc_area u_area_pbc (.clk(clk), .en(pipe_en),
    .x1(px), .y1(py), .x2(bx), .y2(by), .x3(cx), .y3(cy), .area(s1));
  tpc_area u_area_apc (.clk(clk), .en(pipe_en),
    .x1(ax), .y1(ay), .x2(px), .y2(py), .x3(cx), .y3(cy), .area(s2));
  tpc_area u_area_abp (.clk(clk), .en(pipe_en),
    .x1(ax), .y1(ay), .x2(bx), .y2(by), .x3(px), .y3(py), .area(s3));

  logic                   sb_valid_r [AREA_STAGES];
  logic                   sb_in_r    [AREA_STAGES];
  logic [TRI_ID_BITS-1:0] sb_tri_r   [AREA_STAGES];
  logic [PIX_BITS-1:0]    sb_idx_r   [AREA_STAGES];
  logic                   sb_in_nxt;

  assign sb_in_nxt = FRAME_BITS'(dq.item.pixel_index) < total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < AREA_STAGES; s++) begin
        sb_valid_r[s] <= 1'b0;
      end
    end else if (pipe_en) begin
      sb_valid_r[0] <= dq.valid;
      for (int s = 1; s < AREA_STAGES; s++) begin
        sb_valid_r[s] <= sb_valid_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sb_in_r[0]  <= sb_in_nxt;
      sb_tri_r[0] <= dq.item.tri_id;
      sb_idx_r[0] <= dq.item.pixel_index;
      for (int s = 1; s < AREA_STAGES; s++) begin
        sb_in_r[s]  <= sb_in_r[s-1];
        sb_tri_r[s] <= sb_tri_r[s-1];
        sb_idx_r[s] <= sb_idx_r[s-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: exact compare of the sub-area sum against the whole.
  // ---------------------------------------------------------------------
  localparam int ASUM_BITS = AREA_BITS + 2;

  logic [ASUM_BITS-1:0]   sub_sum;
  logic                   e_hit_nxt;
  logic [TRI_ID_BITS-1:0] e_tri_r;
  logic [PIX_BITS-1:0]    e_idx_r;

  assign sub_sum   = ASUM_BITS'(s1) + ASUM_BITS'(s2) + ASUM_BITS'(s3);
  assign e_hit_nxt = sb_in_r[AREA_STAGES-1] && (sub_sum == ASUM_BITS'(whole));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (pipe_en) begin
      e_valid_r <= sb_valid_r[AREA_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      e_hit_r <= e_hit_nxt;
      e_tri_r <= sb_tri_r[AREA_STAGES-1];
      e_idx_r <= sb_idx_r[AREA_STAGES-1];
    end
  end

  // ---------------------------------------------------------------------
  // Output register: loads each hit leaving the compare stage.
  // ---------------------------------------------------------------------
  logic                   out_load;
  logic                   out_valid_nxt;
  logic [TRI_ID_BITS-1:0] out_tri_r;
  logic [PIX_BITS-1:0]    out_idx_r;

  assign out_load = pipe_en && e_valid_r && e_hit_r;

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tri_r <= e_tri_r;
      out_idx_r <= e_idx_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit_tri_id      = out_tri_r;
  assign out_hit_pixel_index = out_idx_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready && e_valid_r && e_hit_r |-> !in_ready)
    else $error("input accepted while a hit is blocked");

  a_hit_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("hit lost on the way to the output register");

  a_stall_keeps_compare: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(e_valid_r) && $stable(e_hit_r) && $stable(e_idx_r))
    else $error("compare stage changed during a stall");

  a_result_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> FRAME_BITS'(out_idx_r) < total_r)
    else $error("result index outside the frame");

endmodule

// ===== dv/tpc_coverage_checker.sv =====
// Coverage checker: predicts triangle hits from accepted items and compares each result item.
`timescale 1ns / 100ps
module tpc_coverage_checker import tpc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [TRI_ID_BITS-1:0]  in_tri_id,
  input  logic [COORD_BITS-1:0]   in_a_x,
  input  logic [COORD_BITS-1:0]   in_a_y,
  input  logic [COORD_BITS-1:0]   in_b_x,
  input  logic [COORD_BITS-1:0]   in_b_y,
  input  logic [COORD_BITS-1:0]   in_c_x,
  input  logic [COORD_BITS-1:0]   in_c_y,
  input  logic [PIX_BITS-1:0]     in_pixel_index,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [TRI_ID_BITS-1:0]  out_hit_tri_id,
  input  logic [PIX_BITS-1:0]     out_hit_pixel_index,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic [TRI_ID_BITS-1:0] tri_id;
    logic [PIX_BITS-1:0]    pixel_index;
  } exp_item_t;

  logic [CFG_BITS-1:0] width_r;
  logic [CFG_BITS-1:0] height_r;
  exp_item_t           exp_q [$];

  task automatic report(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    fail_count++;
  endtask

  // |trunc(doubled signed area / 2)|
  function automatic longint half_area(input longint x1, input longint y1,
                                       input longint x2, input longint y2,
                                       input longint x3, input longint y3);
    longint twice;
    longint h;
    twice = x1 * (y2 - y3) + x2 * (y3 - y1) + x3 * (y1 - y2);
    h = twice / 2;
    return (h < 0) ? -h : h;
  endfunction

  function automatic logic covers(input longint w, input longint h, input tpc_item_t it);
    longint idx;
    longint px;
    longint py;
    longint ax, ay, bx, by, cx, cy;
    longint whole;
    longint s1, s2, s3;
    idx = longint'(it.pixel_index);
    if (w == 0 || idx >= w * h) begin
      return 1'b0;
    end
    px = idx % w;
    py = idx / w;
    ax = longint'(it.a_x);
    ay = longint'(it.a_y);
    bx = longint'(it.b_x);
    by = longint'(it.b_y);
    cx = longint'(it.c_x);
    cy = longint'(it.c_y);
    whole = half_area(ax, ay, bx, by, cx, cy);
    s1    = half_area(px, py, bx, by, cx, cy);
    s2    = half_area(ax, ay, px, py, cx, cy);
    s3    = half_area(ax, ay, bx, by, px, py);
    return (whole == s1 + s2 + s3);
  endfunction

  always @(posedge clk) begin
    exp_item_t want;
    exp_item_t got;
    tpc_item_t it;
    if (!rst_n) begin
      width_r  <= FRAME_WIDTH_RST;
      height_r <= FRAME_HEIGHT_RST;
      exp_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.tri_id      = out_hit_tri_id;
        got.pixel_index = out_hit_pixel_index;
        if (exp_q.size() == 0) begin
          report($sformatf("unexpected result item tri %0d pixel %0d",
                           got.tri_id, got.pixel_index));
        end else begin
          want = exp_q.pop_front();
          if (got != want) begin
            report($sformatf("result tri %0d pixel %0d, expected tri %0d pixel %0d",
                             got.tri_id, got.pixel_index, want.tri_id, want.pixel_index));
          end
        end
      end
      if (in_valid && in_ready) begin
        it.tri_id      = in_tri_id;
        it.a_x         = in_a_x;
        it.a_y         = in_a_y;
        it.b_x         = in_b_x;
        it.b_y         = in_b_y;
        it.c_x         = in_c_x;
        it.c_y         = in_c_y;
        it.pixel_index = in_pixel_index;
        if (covers(longint'(width_r), longint'(height_r), it)) begin
          want.tri_id      = it.tri_id;
          want.pixel_index = it.pixel_index;
          exp_q.push_back(want);
        end
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_FRAME_WIDTH:  width_r  <= cfg_data;
          CFG_FRAME_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
    end
    pending <= exp_q.size();
  end

endmodule

// ===== dv/tb_triangle_pixel_coverage_core.sv =====
// Testbench top: clock, reset, item/config stimulus and the final verdict.
`timescale 1ns / 100ps
module tb_triangle_pixel_coverage_core import tpc_pkg::*; ;

  localparam int N_ITEMS          = 1100;
  localparam int N_SEGS           = 6;
  localparam int SEG_ITEMS        = N_ITEMS / N_SEGS;
  localparam int NO_IDLE_ITEMS    = 150;
  localparam int LONG_HOLD_AT     = 250;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES     = 30;
  localparam int CYCLE_LIMIT      = 100000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [TRI_ID_BITS-1:0]  in_tri_id = '0;
  logic [COORD_BITS-1:0]   in_a_x = '0;
  logic [COORD_BITS-1:0]   in_a_y = '0;
  logic [COORD_BITS-1:0]   in_b_x = '0;
  logic [COORD_BITS-1:0]   in_b_y = '0;
  logic [COORD_BITS-1:0]   in_c_x = '0;
  logic [COORD_BITS-1:0]   in_c_y = '0;
  logic [PIX_BITS-1:0]     in_pixel_index = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [TRI_ID_BITS-1:0]  out_hit_tri_id;
  logic [PIX_BITS-1:0]     out_hit_pixel_index;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]     cfg_data = '0;

  int   fail_count;
  int   pending;
  int   n_sent = 0;
  int   cycle_cnt_r = 0;
  logic no_idle;

  assign no_idle = (n_sent >= N_ITEMS - NO_IDLE_ITEMS);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_cnt_r <= cycle_cnt_r + 1;
    if (cycle_cnt_r >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  triangle_pixel_coverage_core u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_tri_id           (in_tri_id),
    .in_a_x              (in_a_x),
    .in_a_y              (in_a_y),
    .in_b_x              (in_b_x),
    .in_b_y              (in_b_y),
    .in_c_x              (in_c_x),
    .in_c_y              (in_c_y),
    .in_pixel_index      (in_pixel_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hit_tri_id      (out_hit_tri_id),
    .out_hit_pixel_index (out_hit_pixel_index),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  tpc_coverage_checker u_chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_tri_id           (in_tri_id),
    .in_a_x              (in_a_x),
    .in_a_y              (in_a_y),
    .in_b_x              (in_b_x),
    .in_b_y              (in_b_y),
    .in_c_x              (in_c_x),
    .in_c_y              (in_c_y),
    .in_pixel_index      (in_pixel_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hit_tri_id      (out_hit_tri_id),
    .out_hit_pixel_index (out_hit_pixel_index),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  // frame per segment: reset size, small, full, one column, zero width, wide
  task automatic seg_frame(input int seg, output int w, output int h);
    unique case (seg)
      0: begin
        w = 640;
        h = 480;
      end
      1: begin
        w = 37;
        h = 29;
      end
      2: begin
        w = 4096;
        h = 4096;
      end
      3: begin
        w = 1;
        h = 5000;
      end
      4: begin
        w = 0;
        h = 100;
      end
      default: begin
        w = 8191;
        h = 2047;
      end
    endcase
  endtask

  function automatic tpc_item_t make_item(input int w, input int h);
    tpc_item_t it;
    int lim_x, lim_y;
    int ax, ay, bx, by, cx, cy;
    int px, py, idx, pmode;
    lim_x = (w == 0) ? 4096 : ((w < 4096) ? w : 4096);
    lim_y = (h == 0) ? 4096 : ((h < 4096) ? h : 4096);
    ax = int'($urandom_range(lim_x - 1, 0));
    ay = int'($urandom_range(lim_y - 1, 0));
    bx = int'($urandom_range(lim_x - 1, 0));
    by = int'($urandom_range(lim_y - 1, 0));
    cx = int'($urandom_range(lim_x - 1, 0));
    cy = int'($urandom_range(lim_y - 1, 0));
    // collinear vertices now and then
    if ($urandom_range(99, 0) < 15) begin
      cx = bx;
      cy = by;
    end
    pmode = int'($urandom_range(99, 0));
    if (pmode < 35) begin
      px  = (ax + bx + cx) / 3;
      py  = (ay + by + cy) / 3;
      idx = py * w + px;
    end else if (pmode < 45) begin
      idx = ay * w + ax;
    end else if (pmode < 55) begin
      px  = (ax + bx) / 2;
      py  = (ay + by) / 2;
      idx = py * w + px;
    end else if (pmode < 90 && w * h > 0) begin
      idx = int'($urandom_range(w * h - 1, 0));
    end else begin
      idx = int'($urandom());
    end
    it.tri_id      = TRI_ID_BITS'($urandom());
    it.a_x         = COORD_BITS'(ax);
    it.a_y         = COORD_BITS'(ay);
    it.b_x         = COORD_BITS'(bx);
    it.b_y         = COORD_BITS'(by);
    it.c_x         = COORD_BITS'(cx);
    it.c_y         = COORD_BITS'(cy);
    it.pixel_index = PIX_BITS'(idx);
    return it;
  endfunction

  task automatic send_item(input tpc_item_t it);
    in_valid       <= 1'b1;
    in_tri_id      <= it.tri_id;
    in_a_x         <= it.a_x;
    in_a_y         <= it.a_y;
    in_b_x         <= it.b_x;
    in_b_y         <= it.b_y;
    in_c_x         <= it.c_x;
    in_c_y         <= it.c_y;
    in_pixel_index <= it.pixel_index;
    do @(posedge clk); while (!in_ready);
  endtask

  // cfg_valid is left high; the caller drops it after the last write
  task automatic write_cfg(input cfg_idx_t idx, input logic [CFG_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // stop sending, wait for every expected result, then let misses flush out
  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    tpc_item_t it;
    int w, h, n_seg;
    wait (rst_n === 1'b1);
    @(posedge clk);
    for (int seg = 0; seg < N_SEGS; seg++) begin
      seg_frame(seg, w, h);
      if (seg != 0) begin
        drain();
        write_cfg(CFG_FRAME_WIDTH, CFG_BITS'(w));
        write_cfg(CFG_FRAME_HEIGHT, CFG_BITS'(h));
        cfg_valid <= 1'b0;
      end
      n_seg = (seg == N_SEGS - 1) ? N_ITEMS - n_sent : SEG_ITEMS;
      for (int i = 0; i < n_seg; i++) begin
        it = make_item(w, h);
        send_item(it);
        n_sent++;
        if (!no_idle && $urandom_range(99, 0) < 25) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(10, 1)) @(posedge clk);
        end
      end
    end
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : receiver
    int   hold_cnt;
    logic hold_done;
    hold_done = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!hold_done && n_sent >= LONG_HOLD_AT) begin
        out_ready <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < LONG_HOLD_CYCLES) begin
          @(posedge clk);
          hold_cnt++;
        end
        hold_done = 1'b1;
      end else if (no_idle) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(10, 1)) @(posedge clk);
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 1)) @(posedge clk);
      end
    end
  end

endmodule

// ===== sim.f =====
sv/tpc_pkg.sv
sv/tpc_div_pipe.sv
sv/tpc_area.sv
sv/triangle_pixel_coverage_core.sv
dv/tpc_coverage_checker.sv
dv/tb_triangle_pixel_coverage_core.sv
